>>> hdl/fmsct_pkg.sv
// Types, microcode program and lookup tables for the FM song command translator.
package fmsct_pkg;

  localparam int INSTRUMENT_SLOTS_DEF = 256;
  localparam int MELODIC_CHANNELS     = 6;
  localparam int VOICES               = 11;
  localparam int BYTES_PER_INS        = 16;
  localparam int VOLUME_MAX           = 30;

  localparam logic       REQ_STORE  = 1'b1;
  localparam logic [7:0] NO_SLOT    = 8'hff;
  localparam logic [7:0] REG_KEYS   = 8'hbd;
  localparam logic [7:0] REG_BLOCK  = 8'hb0;
  localparam logic [7:0] REG_FNUM   = 8'ha0;
  localparam logic [7:0] KEY_ON     = 8'h20;
  localparam logic [7:0] KEYS_RESET = 8'he0;
  localparam logic [7:0] PERC_BIT   = 8'h10;
  localparam logic [5:0] LEVEL_MAX  = 6'h3f;

  typedef enum logic [2:0] {
    CMD_DELAY   = 3'd0,
    CMD_PROGRAM = 3'd1,
    CMD_NOTE_ON = 3'd2,
    CMD_NOTE_OFF = 3'd3,
    CMD_VOLUME  = 3'd4,
    CMD_LJUMP   = 3'd5,
    CMD_LMARK   = 3'd6,
    CMD_EVENT   = 3'd7
  } cmd_t;

  typedef enum logic [2:0] {
    K_WRITE   = 3'd0,
    K_DELAY   = 3'd1,
    K_LMARK   = 3'd2,
    K_LJUMP   = 3'd3,
    K_EVENT   = 3'd4,
    K_IGNORED = 3'd5
  } kind_t;

  typedef enum logic [4:0] {
    S_IGN    = 5'd0,
    S_DELAY  = 5'd1,
    S_LJUMP  = 5'd2,
    S_LMARK  = 5'd3,
    S_EVENT  = 5'd4,
    S_OFF    = 5'd5,
    S_PREL   = 5'd6,
    S_P0     = 5'd7,
    S_P1     = 5'd8,
    S_P2     = 5'd9,
    S_P3     = 5'd10,
    S_P4     = 5'd11,
    S_P5     = 5'd12,
    S_P6     = 5'd13,
    S_P7     = 5'd14,
    S_P8     = 5'd15,
    S_P9     = 5'd16,
    S_PVOICE = 5'd17,
    S_NREL   = 5'd18,
    S_NFNUM  = 5'd19,
    S_NBLOCK = 5'd20,
    S_NKEY   = 5'd21,
    S_V0     = 5'd22,
    S_V1     = 5'd23,
    S_V2     = 5'd24,
    S_END    = 5'd25
  } step_t;

  typedef enum logic [2:0] {
    A_ZERO, A_SLOT, A_RELEASE, A_FNUM, A_BLOCK, A_KEYS
  } asel_t;

  typedef enum logic [2:0] {
    V_ZERO, V_ARG, V_MEM, V_LEVEL, V_RELEASE, V_FNUM, V_BLOCK, V_KEYS_SET
  } vsel_t;

  typedef enum logic [2:0] {
    C_NEVER, C_ALWAYS, C_NO_OP2, C_NO_VOICE, C_OP1_DONE, C_PERC_HI, C_MELODIC, C_NO_MOD
  } cond_t;

  typedef struct packed {
    logic       emit;
    kind_t      kind;
    asel_t      asel;
    vsel_t      vsel;
    logic [3:0] byte_idx;
    cond_t      cond;
    step_t      target;
  } ctrl_t;

  typedef logic [7:0] wrap_tbl_t [256];

  // Instrument number folded into the store, built by counting.
  function automatic wrap_tbl_t make_wrap(int slots);
    wrap_tbl_t t;
    int        cnt;
    cnt = 0;
    for (int i = 0; i < 256; i++) begin
      t[i] = 8'(cnt);
      cnt  = cnt + 1;
      if (cnt == slots) cnt = 0;
    end
    return t;
  endfunction

  function automatic ctrl_t ucode(step_t s);
    ctrl_t c;
    c.emit     = 1'b1;
    c.kind     = K_WRITE;
    c.asel     = A_ZERO;
    c.vsel     = V_ZERO;
    c.byte_idx = 4'd0;
    c.cond     = C_ALWAYS;
    c.target   = S_END;
    unique case (s)
      S_IGN:    c.kind = K_IGNORED;
      S_DELAY:  begin c.kind = K_DELAY; c.vsel = V_ARG; end
      S_LJUMP:  c.kind = K_LJUMP;
      S_LMARK:  c.kind = K_LMARK;
      S_EVENT:  begin c.kind = K_EVENT; c.vsel = V_ARG; end
      S_OFF:    begin c.asel = A_RELEASE; c.vsel = V_RELEASE; end
      S_PREL:   begin c.asel = A_RELEASE; c.vsel = V_RELEASE; c.cond = C_NEVER; end
      S_P0:     begin c.asel = A_SLOT; c.vsel = V_MEM; c.byte_idx = 4'd0; c.cond = C_NEVER; end
      S_P1:     begin c.asel = A_SLOT; c.vsel = V_MEM; c.byte_idx = 4'd1; c.cond = C_NEVER; end
      S_P2:     begin c.asel = A_SLOT; c.vsel = V_MEM; c.byte_idx = 4'd2; c.cond = C_NEVER; end
      S_P3:     begin c.asel = A_SLOT; c.vsel = V_MEM; c.byte_idx = 4'd3; c.cond = C_NEVER; end
      S_P4:     begin
        c.asel = A_SLOT; c.vsel = V_MEM; c.byte_idx = 4'd4;
        c.cond = C_OP1_DONE; c.target = S_PVOICE;
      end
      S_P5:     begin c.asel = A_SLOT; c.vsel = V_MEM; c.byte_idx = 4'd5; c.cond = C_NEVER; end
      S_P6:     begin c.asel = A_SLOT; c.vsel = V_MEM; c.byte_idx = 4'd6; c.cond = C_NEVER; end
      S_P7:     begin c.asel = A_SLOT; c.vsel = V_MEM; c.byte_idx = 4'd7; c.cond = C_NEVER; end
      S_P8:     begin c.asel = A_SLOT; c.vsel = V_MEM; c.byte_idx = 4'd8; c.cond = C_NEVER; end
      S_P9:     begin
        c.asel = A_SLOT; c.vsel = V_MEM; c.byte_idx = 4'd9; c.cond = C_NO_VOICE;
      end
      S_PVOICE: begin c.asel = A_SLOT; c.vsel = V_MEM; c.byte_idx = 4'd10; end
      S_NREL:   begin
        c.asel = A_RELEASE; c.vsel = V_RELEASE; c.cond = C_PERC_HI; c.target = S_NKEY;
      end
      S_NFNUM:  begin c.asel = A_FNUM; c.vsel = V_FNUM; c.cond = C_NEVER; end
      S_NBLOCK: begin c.asel = A_BLOCK; c.vsel = V_BLOCK; c.cond = C_MELODIC; end
      S_NKEY:   begin c.asel = A_KEYS; c.vsel = V_KEYS_SET; end
      S_V0:     begin
        c.emit = 1'b0; c.byte_idx = 4'd10; c.cond = C_NO_OP2; c.target = S_V2;
      end
      S_V1:     begin
        c.asel = A_SLOT; c.vsel = V_LEVEL; c.byte_idx = 4'd6; c.cond = C_NO_MOD;
      end
      S_V2:     begin c.asel = A_SLOT; c.vsel = V_LEVEL; c.byte_idx = 4'd1; end
      default:  c.emit = 1'b0;
    endcase
    return c;
  endfunction

  function automatic step_t entry_step(cmd_t cmd, logic [3:0] ch);
    step_t s;
    unique case (cmd)
      CMD_DELAY:    s = S_DELAY;
      CMD_PROGRAM:  s = S_PREL;
      CMD_NOTE_ON:  s = S_NREL;
      CMD_NOTE_OFF: s = S_OFF;
      CMD_VOLUME:   s = S_V0;
      CMD_LJUMP:    s = S_LJUMP;
      CMD_LMARK:    s = S_LMARK;
      default:      s = S_EVENT;
    endcase
    if ((cmd == CMD_PROGRAM || cmd == CMD_NOTE_ON || cmd == CMD_NOTE_OFF ||
         cmd == CMD_VOLUME) && 32'(ch) >= VOICES) begin
      s = S_IGN;
    end
    return s;
  endfunction

  function automatic logic [7:0] op1_slot(logic [3:0] ch);
    case (ch)
      4'd0: return 8'h00;
      4'd1: return 8'h01;
      4'd2: return 8'h02;
      4'd3: return 8'h08;
      4'd4: return 8'h09;
      4'd5: return 8'h0a;
      4'd6: return 8'h10;
      4'd7: return 8'h14;
      4'd8: return 8'h12;
      4'd9: return 8'h15;
      4'd10: return 8'h11;
      default: return NO_SLOT;
    endcase
  endfunction

  function automatic logic [7:0] op2_slot(logic [3:0] ch);
    case (ch)
      4'd0: return 8'h03;
      4'd1: return 8'h04;
      4'd2: return 8'h05;
      4'd3: return 8'h0b;
      4'd4: return 8'h0c;
      4'd5: return 8'h0d;
      4'd6: return 8'h13;
      default: return NO_SLOT;
    endcase
  endfunction

  function automatic logic [7:0] voice_of(logic [3:0] ch);
    case (ch) inside
      [4'd0:4'd7]: return {4'd0, ch};
      4'd9:        return 8'd8;
      default:     return NO_SLOT;
    endcase
  endfunction

  function automatic logic [7:0] reg_base(logic [3:0] b);
    case (b)
      4'd0, 4'd5: return 8'h20;
      4'd1, 4'd6: return 8'h40;
      4'd2, 4'd7: return 8'h60;
      4'd3, 4'd8: return 8'h80;
      4'd4, 4'd9: return 8'he0;
      default:    return 8'hc0;
    endcase
  endfunction

  function automatic logic [5:0] atten_add(logic [4:0] v);
    case (v) inside
      5'd0:           return 6'd63;
      5'd1:           return 6'd20;
      5'd2:           return 6'd16;
      5'd3:           return 6'd14;
      5'd4:           return 6'd12;
      5'd5:           return 6'd10;
      5'd6:           return 6'd9;
      5'd7:           return 6'd8;
      5'd8:           return 6'd7;
      5'd9, 5'd10:    return 6'd6;
      5'd11, 5'd12:   return 6'd5;
      [5'd13:5'd17]:  return 6'd4;
      [5'd18:5'd21]:  return 6'd3;
      [5'd22:5'd24]:  return 6'd2;
      [5'd25:5'd28]:  return 6'd1;
      default:        return 6'd0;
    endcase
  endfunction

  function automatic logic [7:0] fnum_low(logic [3:0] k);
    case (k)
      4'd0:  return 8'hac;
      4'd1:  return 8'hb6;
      4'd2:  return 8'hc1;
      4'd3:  return 8'hcd;
      4'd4:  return 8'hd9;
      4'd5:  return 8'he6;
      4'd6:  return 8'hf3;
      4'd7:  return 8'h02;
      4'd8:  return 8'h11;
      4'd9:  return 8'h22;
      4'd10: return 8'h33;
      4'd11: return 8'h45;
      default: return 8'h00;
    endcase
  endfunction

endpackage

>>> hdl/fm_song_command_translator_top.sv
// Microcoded translator from song command words to FM register writes and notices.
// A command word is taken when the sequencer is idle; its steps then run from the step register and
// the output register takes one result per cycle while out_stall is low (one idle step for volume).
// The input is stalled while a word runs: program change gives up to 12 results, note on up to 4,
// volume up to 2. Store byte writes give no result.
// rst_n (synchronous) idles the sequencer and output, clears channel instruments, keys to 0xe0.
module fm_song_command_translator_top
  import fmsct_pkg::*;
#(
  parameter int INSTRUMENT_SLOTS = INSTRUMENT_SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_req_type,
  input  logic [2:0]  in_command,
  input  logic [3:0]  in_channel,
  input  logic [7:0]  in_argument,
  input  logic [11:0] in_store_address,
  input  logic [7:0]  in_store_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_kind,
  output logic [7:0]  out_reg_address,
  output logic [7:0]  out_value,
  output logic        out_last
);

  localparam int STORE_DEPTH = INSTRUMENT_SLOTS * BYTES_PER_INS;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam wrap_tbl_t WRAP = make_wrap(INSTRUMENT_SLOTS);

  logic [7:0]  store_mem [STORE_DEPTH];
  logic [7:0]  mem_q_r;

  step_t       step_r, step_nxt;
  logic [3:0]  ch_r;
  logic [7:0]  arg_r;
  logic [7:0]  ins_r;
  logic [7:0]  keys_r, keys_nxt;
  logic        mod_r;
  logic [7:0]  chan_ins_r [VOICES];

  logic        out_valid_r;
  logic [2:0]  out_kind_r;
  logic [7:0]  out_addr_r;
  logic [7:0]  out_value_r;
  logic        out_last_r;

  ctrl_t       ctl, entry_ctl, nxt_ctl;
  logic        busy, accept, accept_cmd, accept_store, advance, out_free;
  logic        has_op2, has_voice, cond_hit;
  step_t       jump_to, entry;
  logic [3:0]  ch_idx;
  logic [7:0]  ins_src, ins_wrap;
  logic [3:0]  rd_byte;
  logic [11:0] rd_addr12;
  logic [7:0]  slot, perc_mask, addr_d, val_d;
  logic [6:0]  note, q12;
  logic [14:0] q_prod;
  logic [3:0]  octave, key_idx;
  logic [7:0]  block_byte;
  logic [4:0]  vol;
  logic [6:0]  lvl_sum;
  logic [5:0]  lvl;

  assign busy         = (step_r != S_END);
  assign in_stall     = busy;
  assign accept       = in_valid && !busy;
  assign accept_cmd   = accept && (in_req_type != REQ_STORE);
  assign accept_store = accept && (in_req_type == REQ_STORE);
  assign out_free     = !out_valid_r || !out_stall;

  assign ctl       = ucode(step_r);
  assign advance   = busy && (!ctl.emit || out_free);
  assign has_op2   = (op2_slot(ch_r) != NO_SLOT);
  assign has_voice = (voice_of(ch_r) != NO_SLOT);

  // Sequencer: step counter with conditional jumps from the control word.
  always_comb begin
    jump_to = ctl.target;
    unique case (ctl.cond)
      C_NEVER:    cond_hit = 1'b0;
      C_ALWAYS:   cond_hit = 1'b1;
      C_NO_OP2:   cond_hit = !has_op2;
      C_NO_VOICE: cond_hit = !has_voice;
      C_OP1_DONE: begin
        cond_hit = !has_op2;
        if (!has_voice) jump_to = S_END;
      end
      C_PERC_HI:  cond_hit = (ch_r > 4'(MELODIC_CHANNELS));
      C_MELODIC:  cond_hit = (ch_r < 4'(MELODIC_CHANNELS));
      C_NO_MOD:   cond_hit = !mod_r;
      default:    cond_hit = 1'b1;
    endcase
    step_nxt = cond_hit ? jump_to : step_t'(step_r + 5'd1);
  end

  // Instrument store read: prefetch the byte the next step consumes.
  assign entry     = entry_step(cmd_t'(in_command), in_channel);
  assign entry_ctl = ucode(entry);
  assign nxt_ctl   = ucode(step_nxt);
  assign ch_idx    = (in_channel < 4'(VOICES)) ? in_channel : 4'd0;
  assign ins_src   = (cmd_t'(in_command) == CMD_VOLUME) ? chan_ins_r[ch_idx] : in_argument;
  assign ins_wrap  = WRAP[ins_src];
  assign rd_byte   = accept_cmd ? entry_ctl.byte_idx : nxt_ctl.byte_idx;
  assign rd_addr12 = {(accept_cmd ? ins_wrap : ins_r), rd_byte};

  always_ff @(posedge clk) begin
    if (accept_store && ({1'b0, in_store_address} < 13'(STORE_DEPTH))) begin
      store_mem[in_store_address[ADDR_W-1:0]] <= in_store_byte;
    end
    if (accept_cmd || advance) begin
      mem_q_r <= store_mem[rd_addr12[ADDR_W-1:0]];
    end
  end

  // Datapath
  always_comb begin
    note    = arg_r[6:0];
    q_prod  = 15'(note) * 15'd171;
    octave  = q_prod[14:11];
    q12     = 7'({octave, 3'b000}) + 7'({octave, 2'b00});
    key_idx = 4'(note - q12);
    block_byte = {2'b00, 4'(octave + 4'd2), 1'b0, (key_idx >= 4'd7)};

    vol     = (arg_r > 8'(VOLUME_MAX)) ? 5'(VOLUME_MAX) : arg_r[4:0];
    lvl_sum = {1'b0, mem_q_r[5:0]} + {1'b0, atten_add(vol)};
    lvl     = (lvl_sum > {1'b0, LEVEL_MAX}) ? LEVEL_MAX : lvl_sum[5:0];

    perc_mask = PERC_BIT >> (ch_r - 4'(MELODIC_CHANNELS));

    if (ctl.byte_idx < 4'd5)       slot = op1_slot(ch_r);
    else if (ctl.byte_idx < 4'd10) slot = op2_slot(ch_r);
    else                           slot = voice_of(ch_r);

    keys_nxt = keys_r;
    if (ctl.vsel == V_RELEASE && ch_r >= 4'(MELODIC_CHANNELS)) keys_nxt = keys_r & ~perc_mask;
    if (ctl.vsel == V_KEYS_SET)                                keys_nxt = keys_r | perc_mask;

    unique case (ctl.asel)
      A_ZERO:    addr_d = 8'h00;
      A_SLOT:    addr_d = slot + reg_base(ctl.byte_idx);
      A_RELEASE: addr_d = (ch_r < 4'(MELODIC_CHANNELS)) ? REG_BLOCK + {4'd0, ch_r} : REG_KEYS;
      A_FNUM:    addr_d = REG_FNUM + voice_of(ch_r);
      A_BLOCK:   addr_d = REG_BLOCK + voice_of(ch_r);
      A_KEYS:    addr_d = REG_KEYS;
      default:   addr_d = 8'h00;
    endcase

    unique case (ctl.vsel)
      V_ZERO:     val_d = 8'h00;
      V_ARG:      val_d = arg_r;
      V_MEM:      val_d = mem_q_r;
      V_LEVEL:    val_d = {mem_q_r[7:6], lvl};
      V_RELEASE:  val_d = (ch_r < 4'(MELODIC_CHANNELS)) ? 8'h00 : keys_nxt;
      V_FNUM:     val_d = fnum_low(key_idx);
      V_BLOCK:    val_d = (ch_r < 4'(MELODIC_CHANNELS)) ? (block_byte | KEY_ON) : block_byte;
      V_KEYS_SET: val_d = keys_nxt;
      default:    val_d = 8'h00;
    endcase
  end

  // Control and channel state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= S_END;
      keys_r <= KEYS_RESET;
      for (int i = 0; i < VOICES; i++) chan_ins_r[i] <= 8'h00;
    end else begin
      if (accept_cmd) begin
        step_r <= entry;
        if (cmd_t'(in_command) == CMD_PROGRAM && in_channel < 4'(VOICES)) begin
          chan_ins_r[ch_idx] <= in_argument;
        end
      end else if (advance) begin
        step_r <= step_nxt;
        keys_r <= keys_nxt;
      end
    end
  end

  // Word payload, held for the run of the sequence
  always_ff @(posedge clk) begin
    if (accept_cmd) begin
      ch_r  <= in_channel;
      arg_r <= in_argument;
      ins_r <= ins_wrap;
    end
    if (advance && step_r == S_V0) begin
      mod_r <= mem_q_r[0];
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && ctl.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && ctl.emit) begin
      out_kind_r  <= ctl.kind;
      out_addr_r  <= addr_d;
      out_value_r <= val_d;
      out_last_r  <= (step_nxt == S_END);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_kind        = out_kind_r;
  assign out_reg_address = out_addr_r;
  assign out_value       = out_value_r;
  assign out_last        = out_last_r;

endmodule
